>>> hdl/pme_pkg.sv
// ----------------------------------------------------------------------------
// pme_pkg
// Shared types and constants for the point-mass Euler step block.
// ----------------------------------------------------------------------------
package pme_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;
   localparam int FACTOR_BITS   = 14;
   localparam int REG_BITS      = 31;
   localparam int IO_BITS       = 32;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_SPEED  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BODY_MASS  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRAVITY_ON = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRAV_TICK  = 2'd3;

   localparam logic [REG_BITS-1:0] MAX_SPEED_RST = 31'd6553600;
   localparam logic [REG_BITS-1:0] BODY_MASS_RST = 31'd65536;
   localparam logic [REG_BITS-1:0] GRAV_TICK_RST = 31'd178;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GRAV,
      ST_ACC,
      ST_FRIC,
      ST_BNCE,
      ST_MAG,
      ST_SQ,
      ST_CHECK,
      ST_SQRT,
      ST_DIV,
      ST_POS,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic grav;
      logic acc;
      logic fric;
      logic bnce;
      logic mag;
      logic sq;
      logic check;
      logic sqrt_start;
      logic sqrt_step;
      logic div_start;
      logic div_step;
      logic pos;
   } cmd_type;

   typedef struct packed {
      logic fric_nz;
      logic bnce_nz;
      logic trig;
      logic sqrt_done;
      logic div_done;
   } sts_type;

endpackage

>>> hdl/pme_if.sv
// ----------------------------------------------------------------------------
// pme_req_if / pme_rsp_if
// Valid/ready channels for tick requests and state responses.
// ----------------------------------------------------------------------------
interface pme_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] push_x;
   logic signed [31:0] push_y;
   logic signed [31:0] push_z;
   logic               on_ground;
   logic [15:0]        friction_factor;
   logic [15:0]        bounce_factor;
   modport source (output valid, push_x, push_y, push_z, on_ground, friction_factor,
                   bounce_factor, input ready);
   modport sink (input valid, push_x, push_y, push_z, on_ground, friction_factor,
                 bounce_factor, output ready);
endinterface

interface pme_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic               landed;
   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, landed,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, landed,
                 output ready);
endinterface

>>> hdl/point_mass_euler_step.sv
// ----------------------------------------------------------------------------
// point_mass_euler_step
// One semi-implicit Euler step of a point mass per request beat, Q16.16.
// ----------------------------------------------------------------------------
// A step that stays under the speed limit skips the rescale; when the speed
// reaches the limit the velocity is rescaled: the bit-serial square root runs
// once and the shared restoring divider runs once per axis. The response
// beat is held until taken; the next request beat is accepted after.
module point_mass_euler_step import pme_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   pme_req_if.sink                 req,
   pme_rsp_if.source               rsp,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_idx,
   input  logic [REG_BITS-1:0]     csr_wdata
);

   logic [REG_BITS-1:0] max_speed_ff, body_mass_ff, grav_tick_ff;
   logic                gravity_on_ff;
   cmd_type cmd;
   sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= MAX_SPEED_RST;
         body_mass_ff  <= BODY_MASS_RST;
         gravity_on_ff <= 1'b1;
         grav_tick_ff  <= GRAV_TICK_RST;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_MAX_SPEED:  max_speed_ff  <= csr_wdata;
            CSR_BODY_MASS:  body_mass_ff  <= csr_wdata;
            CSR_GRAVITY_ON: gravity_on_ff <= csr_wdata[0];
            CSR_GRAV_TICK:  grav_tick_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   pme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pme_dp #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .max_speed        (max_speed_ff),
      .body_mass        (body_mass_ff),
      .gravity_on       (gravity_on_ff),
      .gravity_per_tick (grav_tick_ff),
      .push_x           (req.push_x),
      .push_y           (req.push_y),
      .push_z           (req.push_z),
      .on_ground        (req.on_ground),
      .friction_factor  (req.friction_factor),
      .bounce_factor    (req.bounce_factor),
      .pos_x            (rsp.pos_x),
      .pos_y            (rsp.pos_y),
      .pos_z            (rsp.pos_z),
      .vel_x            (rsp.vel_x),
      .vel_y            (rsp.vel_y),
      .vel_z            (rsp.vel_z),
      .landed           (rsp.landed)
   );

endmodule

>>> hdl/pme_ctrl.sv
// ----------------------------------------------------------------------------
// pme_ctrl
// Sequencer for one integration step: walks the datapath through its phases.
// ----------------------------------------------------------------------------
module pme_ctrl import pme_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GRAV;
            end
         end
         ST_GRAV: begin
            cmd.grav = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_FRIC;
         end
         ST_FRIC: begin
            cmd.fric = sts.fric_nz;
            state_in = ST_BNCE;
         end
         ST_BNCE: begin
            cmd.bnce = sts.bnce_nz;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.trig) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_SQRT;
            end else begin
               state_in = ST_POS;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_done) begin
               cmd.sqrt_step = 1'b0;
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            cmd.pos  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/pme_dp.sv
// ----------------------------------------------------------------------------
// pme_dp
// Datapath: state vectors, gravity, friction/bounce scaling, speed clamp with
// shared bit-serial square root and divider.
// ----------------------------------------------------------------------------
module pme_dp import pme_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [REG_BITS-1:0]   max_speed,
   input  logic [REG_BITS-1:0]   body_mass,
   input  logic                  gravity_on,
   input  logic [REG_BITS-1:0]   gravity_per_tick,
   input  logic signed [IO_BITS-1:0] push_x,
   input  logic signed [IO_BITS-1:0] push_y,
   input  logic signed [IO_BITS-1:0] push_z,
   input  logic                  on_ground,
   input  logic [15:0]           friction_factor,
   input  logic [15:0]           bounce_factor,
   output logic [IO_BITS-1:0]    pos_x,
   output logic [IO_BITS-1:0]    pos_y,
   output logic [IO_BITS-1:0]    pos_z,
   output logic [IO_BITS-1:0]    vel_x,
   output logic [IO_BITS-1:0]    vel_y,
   output logic [IO_BITS-1:0]    vel_z,
   output logic                  landed
);

   localparam int W      = WORD_BITS;
   localparam int MB     = W;                      // magnitude bits (up to 2^(W-1))
   localparam int SQB    = 2 * MB + 2;             // sum of squares
   localparam int KB     = (MB > 31) ? (MB - 31) : 1;
   localparam int SQR_B  = 64;                     // reduced sum fits in 64
   localparam int ROOT_B = 32;
   localparam int QB     = 63;                     // m (31b) * limit (31b) / s
   localparam int QCB    = $clog2(QB + 1);
   localparam logic [SQB-1:0] MIN_SQ = SQB'((64'd1 << (2 * FRAC_BITS)) / 64'd100000000);
   localparam logic signed [W:0] WMAX = (W+1)'((65'sd1 <<< (W - 1)) - 1);
   localparam logic signed [W:0] WMIN = -WMAX - 1;

   logic signed [W-1:0] vel_ff [3];
   logic signed [W-1:0] pos_ff [3];
   logic                landed_ff;
   logic signed [W:0]   acc_ff [3];
   logic                gnd_ff;
   logic [15:0]         fr_ff, bo_ff;
   logic [MB-1:0]       mag_ff [3];
   logic [SQB-1:0]      sq_ff;
   logic [REG_BITS-1:0] lim_ff;
   logic                neg_ff [3];
   logic [ROOT_B-1:0]   red_ff [3];

   // gravity
   logic [2*REG_BITS-1:0] gprod;
   logic [2*REG_BITS-1:0] gshift;
   logic signed [W-1:0]   g_val;

   always_comb begin
      gprod  = 62'(body_mass) * 62'(gravity_per_tick);
      gshift = gprod >> FRAC_BITS;
      if (gshift > 62'(WMAX)) g_val = WMAX[W-1:0];
      else g_val = W'(gshift);
   end

   function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] x);
      if (x > (W+2)'(WMAX)) return WMAX[W-1:0];
      else if (x < (W+2)'(WMIN)) return WMIN[W-1:0];
      else return x[W-1:0];
   endfunction

   function automatic logic [W:0] absv(input logic signed [W-1:0] v);
      logic signed [W:0] e;
      e = (W+1)'(v);
      return (v < 0) ? (W+1)'(-e) : (W+1)'(e);
   endfunction

   function automatic logic signed [W-1:0] scale(input logic signed [W-1:0] v,
                                                 input logic [15:0] f, input logic neg);
      logic [W+16:0]        p;
      logic [W+16:0]        m;
      logic signed [W+17:0] s;
      logic signed [W-1:0]  r;
      p = (W+17)'(absv(v)) * (W+17)'(f);
      m = p >> FACTOR_BITS;
      s = (v < 0) ? -$signed({1'b0, m}) : $signed({1'b0, m});
      if (s > (W+18)'(WMAX)) r = WMAX[W-1:0];
      else if (s < (W+18)'(WMIN)) r = WMIN[W-1:0];
      else r = s[W-1:0];
      // bounce reflects the already saturated product
      if (neg) r = sat(-((W+2)'(r)));
      return r;
   endfunction

   // magnitude helpers
   logic [MB-1:0] mx;
   logic          low_speed;
   logic [KB-1:0] kshift;

   always_comb begin
      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];
      low_speed = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (mag_ff[i] > MB'(64'd1 << FRAC_BITS)) low_speed = 1'b0;
      end
      kshift = '0;
      for (int k = 0; k <= MB - 31; k++) begin
         if (k > 0 && (mx >> (k - 1)) >= MB'(64'd1 << 31)) kshift = KB'(k);
      end
   end

   logic           zero_small;
   logic           trig;
   logic [2*REG_BITS-1:0] lim_sq;
   always_comb begin
      lim_sq     = 62'(max_speed) * 62'(max_speed);
      zero_small = low_speed && (sq_ff <= MIN_SQ);
      trig       = !zero_small && (max_speed != '0) &&
                   ((mx >= MB'(max_speed)) || (sq_ff >= SQB'(lim_sq)));
   end

   // bit-serial square root over reduced sum of squares
   logic [SQR_B-1:0]  rx_ff, rr_ff, rbit_ff;
   logic              sqrt_done;
   logic [SQR_B-1:0]  red_sum;
   logic [ROOT_B-1:0] red_in [3];
   always_comb begin
      red_sum = '0;
      for (int i = 0; i < 3; i++) begin
         red_in[i] = ROOT_B'(mag_ff[i] >> kshift);
         red_sum  += SQR_B'(red_in[i]) * SQR_B'(red_in[i]);
      end
      sqrt_done = (rbit_ff == '0);
   end

   // restoring divider, one quotient bit per cycle
   logic [1:0]      div_i_ff;
   logic [QCB-1:0]  div_cnt_ff;
   logic [QB-1:0]   dnum_ff;
   logic [QB-1:0]   quo_ff;
   logic [ROOT_B:0] rem_ff;
   logic [ROOT_B-1:0] den;
   logic [ROOT_B:0] rem_sh;
   logic            div_done;
   always_comb begin
      den      = (rr_ff == '0) ? ROOT_B'(1) : ROOT_B'(rr_ff);
      rem_sh   = {rem_ff[ROOT_B-1:0], dnum_ff[QB-1]};
      div_done = (div_i_ff == 2'd2) && (div_cnt_ff == QCB'(QB - 1));
   end

   assign sts.fric_nz   = (fr_ff != '0);
   assign sts.bnce_nz   = (bo_ff != '0);
   assign sts.trig      = trig;
   assign sts.sqrt_done = sqrt_done;
   assign sts.div_done  = div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vel_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
         landed_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            acc_ff[0] <= (W+1)'(push_x);
            acc_ff[1] <= (W+1)'(push_y);
            acc_ff[2] <= (W+1)'(push_z);
            gnd_ff    <= on_ground;
            fr_ff     <= friction_factor;
            bo_ff     <= bounce_factor;
         end
         if (cmd.grav) begin
            if (gravity_on && !gnd_ff) begin
               acc_ff[1] <= (W+1)'((W+2)'(acc_ff[1]) - (W+2)'(g_val));
            end
            if (gnd_ff) begin
               if (!landed_ff) begin
                  landed_ff <= 1'b1;
                  vel_ff[1] <= '0;
               end
            end else begin
               landed_ff <= 1'b0;
            end
         end
         if (cmd.acc) begin
            for (int i = 0; i < 3; i++) vel_ff[i] <= sat((W+2)'(vel_ff[i]) + (W+2)'(acc_ff[i]));
         end
         if (cmd.fric) begin
            for (int i = 0; i < 3; i++) vel_ff[i] <= scale(vel_ff[i], fr_ff, 1'b0);
         end
         if (cmd.bnce) begin
            for (int i = 0; i < 3; i++) vel_ff[i] <= scale(vel_ff[i], bo_ff, 1'b1);
         end
         if (cmd.mag) begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= MB'(absv(vel_ff[i]));
               neg_ff[i] <= vel_ff[i] < 0;
            end
            sq_ff     <= '0;
            lim_ff    <= max_speed;
         end
         if (cmd.sq) begin
            sq_ff <= SQB'(mag_ff[0]) * SQB'(mag_ff[0]) + SQB'(mag_ff[1]) * SQB'(mag_ff[1])
                     + SQB'(mag_ff[2]) * SQB'(mag_ff[2]);
         end
         if (cmd.check) begin
            if (zero_small || max_speed == '0) begin
               for (int i = 0; i < 3; i++) vel_ff[i] <= '0;
            end
            for (int i = 0; i < 3; i++) red_ff[i] <= red_in[i];
         end
         if (cmd.sqrt_start) begin
            rx_ff   <= red_sum;
            rr_ff   <= '0;
            rbit_ff <= SQR_B'(1) << (SQR_B - 2);
         end
         if (cmd.sqrt_step) begin
            if (rbit_ff > rx_ff && rr_ff == '0) begin
               rbit_ff <= rbit_ff >> 2;
            end else if (rx_ff >= rr_ff + rbit_ff) begin
               rx_ff   <= rx_ff - (rr_ff + rbit_ff);
               rr_ff   <= (rr_ff >> 1) + rbit_ff;
               rbit_ff <= rbit_ff >> 2;
            end else begin
               rr_ff   <= rr_ff >> 1;
               rbit_ff <= rbit_ff >> 2;
            end
         end
         if (cmd.div_start) begin
            div_i_ff   <= 2'd0;
            div_cnt_ff <= '0;
            dnum_ff    <= QB'(64'(red_ff[0]) * 64'(lim_ff));
            quo_ff     <= '0;
            rem_ff     <= '0;
         end
         if (cmd.div_step) begin
            if (div_cnt_ff == QCB'(QB - 1)) begin
               div_cnt_ff <= '0;
               rem_ff     <= '0;
               quo_ff     <= '0;
               div_i_ff   <= div_i_ff + 2'd1;
               dnum_ff    <= QB'(64'(red_ff[(div_i_ff == 2'd2) ? 2'd2 : div_i_ff + 2'd1])
                                 * 64'(lim_ff));
               vel_ff[div_i_ff] <= neg_ff[div_i_ff]
                  ? -W'({quo_ff[QB-2:0], (rem_sh >= (ROOT_B+1)'(den))})
                  : W'({quo_ff[QB-2:0], (rem_sh >= (ROOT_B+1)'(den))});
            end else begin
               if (rem_sh >= (ROOT_B+1)'(den)) begin
                  rem_ff <= rem_sh - (ROOT_B+1)'(den);
                  quo_ff <= {quo_ff[QB-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[QB-2:0], 1'b0};
               end
               dnum_ff    <= dnum_ff << 1;
               div_cnt_ff <= div_cnt_ff + QCB'(1);
            end
         end
         if (cmd.pos) begin
            for (int i = 0; i < 3; i++) pos_ff[i] <= pos_ff[i] + vel_ff[i];
         end
      end
   end

   assign pos_x  = IO_BITS'(pos_ff[0]);
   assign pos_y  = IO_BITS'(pos_ff[1]);
   assign pos_z  = IO_BITS'(pos_ff[2]);
   assign vel_x  = IO_BITS'(vel_ff[0]);
   assign vel_y  = IO_BITS'(vel_ff[1]);
   assign vel_z  = IO_BITS'(vel_ff[2]);
   assign landed = landed_ff;

endmodule
